// File: design/bptc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the barometric compensation core.
// No dependencies; imported by bptc_seq and the top level of the core.
package bptc_pkg;

    typedef enum logic
    {
        OP_TEMP  = 1'b0,
        OP_PRESS = 1'b1
    } bptc_op_t;

    // Configuration register indexes
    localparam logic [1:0] REG_OVERSAMPLING = 2'd0;
    localparam logic [1:0] REG_TEMP_CAL     = 2'd1;
    localparam logic [1:0] REG_PRESS_CAL_A  = 2'd2;
    localparam logic [1:0] REG_PRESS_CAL_B  = 2'd3;

    localparam logic [1:0]  OVERSAMPLING_RESET = 2'd1;
    localparam logic [31:0] OFFSET_B6   = 32'd4000;
    localparam logic [31:0] HALF_RANGE  = 32'd32768;
    localparam logic [31:0] PRESS_SCALE = 32'd50000;
    localparam logic [31:0] POLY_A      = 32'd3038;
    localparam logic [31:0] POLY_B_NEG  = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] POLY_C      = 32'd3791;

    typedef struct packed
    {
        logic        kind;
        logic [31:0] value;
        logic        error;
    } bptc_res_t;

    // Arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        logic signed [31:0] t;
        t = v;
        return t >>> s;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] neg32(input logic [31:0] v);
        return ~v + 32'd1;
    endfunction

endpackage

// File: design/bptc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for raw sample items and result items.
// Depends on nothing; used by the top level of the compensation core.
interface bptc_sample_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [23:0] raw_reading;

    modport source (output valid, output opcode, output raw_reading, input ready);
    modport sink   (input valid, input opcode, input raw_reading, output ready);
endinterface

interface bptc_result_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] value;
    logic               error;

    modport source (output valid, output kind, output value, output error, input ready);
    modport sink   (input valid, input kind, input value, input error, output ready);
endinterface

// File: design/bptc_mul.sv
`timescale 1ns / 1ps
// Shared 32x32 multiplier keeping the low 32 bits, product registered.
// No package dependency; driven by the sequencer.
module bptc_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] prod
);

    logic [31:0] prod_reg;

    // Low half of the product is the same for signed and unsigned operands
    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(a * b);
    end

    assign prod = prod_reg;

endmodule

// File: design/bptc_div.sv
`timescale 1ns / 1ps
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// No package dependency; started by the sequencer, pulses done when finished.
module bptc_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quo
);

    localparam int unsigned STEPS = 32;

    logic                       busy_reg;
    logic                       done_reg;
    logic [$clog2(STEPS)-1:0]   cnt_reg;
    logic [31:0]                rem_reg;
    logic [31:0]                quo_reg;
    logic [31:0]                den_reg;
    logic [32:0]                rem_sh;
    logic                       ge;

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                // shift in the next dividend bit, subtract when it fits
                rem_reg <= ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(STEPS))'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: design/bptc_seq.sv
`timescale 1ns / 1ps
// Sequencer and working registers of the compensation core: steps one item
// through the shared multiplier and divider. Imports bptc_pkg.
module bptc_seq
    import bptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        opcode,
    input  logic [23:0] raw,
    input  logic [1:0]  oversampling,
    input  logic [63:0] temp_cal,
    input  logic [63:0] press_cal_a,
    input  logic [31:0] press_cal_b,
    input  logic        res_take,
    output logic        idle,
    output logic        res_valid,
    output bptc_res_t   res
);

    typedef enum logic [5:0]
    {
        S_IDLE,
        S_T_DIFF, S_T_MUL, S_T_X1, S_T_DIV, S_T_WAIT, S_T_SUM, S_T_OUT,
        S_P_LOAD, S_P_SQ_MUL, S_P_SQ, S_P_B2_MUL, S_P_B2, S_P_AC2_MUL, S_P_X3,
        S_P_AC1, S_P_B3, S_P_AC3_MUL, S_P_AC3, S_P_B1_MUL, S_P_B1, S_P_RND,
        S_P_OFS, S_P_AC4_MUL, S_P_B4, S_P_DIFF, S_P_B7_MUL, S_P_DIV, S_P_WAIT,
        S_P_X1, S_P_SQR_MUL, S_P_SQR, S_P_PA_MUL, S_P_PA, S_P_PB_MUL, S_P_PB,
        S_P_PC, S_P_OUT,
        S_RESULT
    } state_t;

    state_t      state_reg;
    logic        kind_reg;
    logic [23:0] raw_reg;
    logic [23:0] up_reg;
    logic [31:0] acc_reg;
    logic [31:0] b6_reg;
    logic [31:0] sq_reg;
    logic [31:0] b3_reg;
    logic [31:0] b4_reg;
    logic [31:0] pv_reg;
    logic [31:0] tt_reg;
    logic [31:0] value_reg;
    logic        err_reg;
    logic        sign_reg;

    logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] div_num, div_den, quo;
    logic        div_start, div_done;
    logic [31:0] num_t, den_t, scale;

    assign ac5 = {16'd0, temp_cal[63:48]};
    assign ac6 = {16'd0, temp_cal[47:32]};
    assign mc  = sx16(temp_cal[31:16]);
    assign md  = sx16(temp_cal[15:0]);
    assign ac1 = sx16(press_cal_a[63:48]);
    assign ac2 = sx16(press_cal_a[47:32]);
    assign ac3 = sx16(press_cal_a[31:16]);
    assign ac4 = {16'd0, press_cal_a[15:0]};
    assign b1  = sx16(press_cal_b[31:16]);
    assign b2  = sx16(press_cal_b[15:0]);

    assign num_t = {mc[20:0], 11'd0};
    assign den_t = acc_reg + md;
    assign scale = PRESS_SCALE >> oversampling;

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_a = acc_reg;
        mul_b = acc_reg;
        case (state_reg)
            S_T_MUL:     begin mul_a = acc_reg;    mul_b = ac5;     end
            S_P_SQ_MUL:  begin mul_a = b6_reg;     mul_b = b6_reg;  end
            S_P_B2_MUL:  begin mul_a = b2;         mul_b = sq_reg;  end
            S_P_AC2_MUL: begin mul_a = ac2;        mul_b = b6_reg;  end
            S_P_AC3_MUL: begin mul_a = ac3;        mul_b = b6_reg;  end
            S_P_B1_MUL:  begin mul_a = b1;         mul_b = sq_reg;  end
            S_P_AC4_MUL: begin mul_a = ac4;        mul_b = acc_reg; end
            S_P_B7_MUL:  begin mul_a = acc_reg;    mul_b = scale;   end
            S_P_SQR_MUL: begin mul_a = acc_reg;    mul_b = acc_reg; end
            S_P_PA_MUL:  begin mul_a = acc_reg;    mul_b = POLY_A;  end
            S_P_PB_MUL:  begin mul_a = POLY_B_NEG; mul_b = pv_reg;  end
            default:     begin mul_a = acc_reg;    mul_b = acc_reg; end
        endcase
    end

    // Divider launch: signed magnitudes for temperature, unsigned for pressure
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (state_reg == S_T_DIV)
        begin
            div_start = den_t != '0;
            div_num   = num_t[31] ? neg32(num_t) : num_t;
            div_den   = den_t[31] ? neg32(den_t) : den_t;
        end
        else if (state_reg == S_P_DIV)
        begin
            div_start = b4_reg != '0;
            div_num   = prod[31] ? prod : {prod[30:0], 1'b0};
            div_den   = b4_reg;
        end
    end

    bptc_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    bptc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= 1'b0;
            raw_reg   <= '0;
            up_reg    <= '0;
            acc_reg   <= '0;
            b6_reg    <= '0;
            sq_reg    <= '0;
            b3_reg    <= '0;
            b4_reg    <= '0;
            pv_reg    <= '0;
            tt_reg    <= '0;
            value_reg <= '0;
            err_reg   <= 1'b0;
            sign_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg  <= opcode;
                        raw_reg   <= raw;
                        err_reg   <= 1'b0;
                        state_reg <= (bptc_op_t'(opcode) == OP_PRESS) ? S_P_LOAD : S_T_DIFF;
                    end
                end

                // Temperature
                S_T_DIFF:
                begin
                    acc_reg   <= {16'd0, raw_reg[15:0]} - ac6;
                    state_reg <= S_T_MUL;
                end
                S_T_MUL:  state_reg <= S_T_X1;
                S_T_X1:
                begin
                    acc_reg   <= asr(prod, 5'd15);
                    state_reg <= S_T_DIV;
                end
                S_T_DIV:
                begin
                    if (den_t == '0)
                    begin
                        err_reg   <= 1'b1;
                        value_reg <= '0;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        sign_reg  <= num_t[31] ^ den_t[31];
                        state_reg <= S_T_WAIT;
                    end
                end
                S_T_WAIT:
                begin
                    if (div_done)
                    begin
                        pv_reg    <= sign_reg ? neg32(quo) : quo;
                        state_reg <= S_T_SUM;
                    end
                end
                S_T_SUM:
                begin
                    tt_reg    <= acc_reg + pv_reg;
                    state_reg <= S_T_OUT;
                end
                S_T_OUT:
                begin
                    value_reg <= asr(tt_reg + 32'd8, 5'd4);
                    state_reg <= S_RESULT;
                end

                // Pressure
                S_P_LOAD:
                begin
                    up_reg    <= raw_reg >> (4'd8 - {2'd0, oversampling});
                    b6_reg    <= tt_reg - OFFSET_B6;
                    state_reg <= S_P_SQ_MUL;
                end
                S_P_SQ_MUL: state_reg <= S_P_SQ;
                S_P_SQ:
                begin
                    sq_reg    <= asr(prod, 5'd12);
                    state_reg <= S_P_B2_MUL;
                end
                S_P_B2_MUL: state_reg <= S_P_B2;
                S_P_B2:
                begin
                    acc_reg   <= asr(prod, 5'd11);
                    state_reg <= S_P_AC2_MUL;
                end
                S_P_AC2_MUL: state_reg <= S_P_X3;
                S_P_X3:
                begin
                    acc_reg   <= acc_reg + asr(prod, 5'd11);
                    state_reg <= S_P_AC1;
                end
                S_P_AC1:
                begin
                    acc_reg   <= {ac1[29:0], 2'd0} + acc_reg;
                    state_reg <= S_P_B3;
                end
                S_P_B3:
                begin
                    b3_reg    <= asr((acc_reg << oversampling) + 32'd2, 5'd2);
                    state_reg <= S_P_AC3_MUL;
                end
                S_P_AC3_MUL: state_reg <= S_P_AC3;
                S_P_AC3:
                begin
                    acc_reg   <= asr(prod, 5'd13);
                    state_reg <= S_P_B1_MUL;
                end
                S_P_B1_MUL: state_reg <= S_P_B1;
                S_P_B1:
                begin
                    acc_reg   <= acc_reg + asr(prod, 5'd16);
                    state_reg <= S_P_RND;
                end
                S_P_RND:
                begin
                    acc_reg   <= asr(acc_reg + 32'd2, 5'd2);
                    state_reg <= S_P_OFS;
                end
                S_P_OFS:
                begin
                    acc_reg   <= acc_reg + HALF_RANGE;
                    state_reg <= S_P_AC4_MUL;
                end
                S_P_AC4_MUL: state_reg <= S_P_B4;
                S_P_B4:
                begin
                    b4_reg    <= prod >> 15;
                    state_reg <= S_P_DIFF;
                end
                S_P_DIFF:
                begin
                    acc_reg   <= {8'd0, up_reg} - b3_reg;
                    state_reg <= S_P_B7_MUL;
                end
                S_P_B7_MUL: state_reg <= S_P_DIV;
                S_P_DIV:
                begin
                    if (b4_reg == '0)
                    begin
                        err_reg   <= 1'b1;
                        value_reg <= '0;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        // top bit set: divide first, double the quotient after
                        sign_reg  <= prod[31];
                        state_reg <= S_P_WAIT;
                    end
                end
                S_P_WAIT:
                begin
                    if (div_done)
                    begin
                        pv_reg    <= sign_reg ? {quo[30:0], 1'b0} : quo;
                        state_reg <= S_P_X1;
                    end
                end
                S_P_X1:
                begin
                    acc_reg   <= asr(pv_reg, 5'd8);
                    state_reg <= S_P_SQR_MUL;
                end
                S_P_SQR_MUL: state_reg <= S_P_SQR;
                S_P_SQR:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_P_PA_MUL;
                end
                S_P_PA_MUL: state_reg <= S_P_PA;
                S_P_PA:
                begin
                    acc_reg   <= asr(prod, 5'd16);
                    state_reg <= S_P_PB_MUL;
                end
                S_P_PB_MUL: state_reg <= S_P_PB;
                S_P_PB:
                begin
                    acc_reg   <= acc_reg + asr(prod, 5'd16);
                    state_reg <= S_P_PC;
                end
                S_P_PC:
                begin
                    acc_reg   <= acc_reg + POLY_C;
                    state_reg <= S_P_OUT;
                end
                S_P_OUT:
                begin
                    value_reg <= pv_reg + asr(acc_reg, 5'd4);
                    state_reg <= S_RESULT;
                end

                // Hold the result until the output stage takes it
                S_RESULT:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign idle      = state_reg == S_IDLE;
    assign res_valid = state_reg == S_RESULT;
    assign res       = '{kind: kind_reg, value: value_reg, error: err_reg};

endmodule

// File: design/baro_pressure_temp_compensation_core.sv
`timescale 1ns / 1ps
// Top level of the barometric compensation core: configuration registers,
// input handshake and output register. Uses bptc_pkg, bptc_if, bptc_seq.
//
// Converts raw sensor readings to temperature (0.1 degree units) or pressure
// (pascals) with the integer datasheet formulas, 32-bit wrapping arithmetic.
// A temperature item also stores the intermediate temperature term that later
// pressure items use (zero after reset). A zero divisor gives error set and
// value zero; a failed temperature item leaves the stored term unchanged.
// One item is in work at a time and goes through the 32-step restoring
// divider and the single shared multiplier that every product goes through
// in turn; a zero divisor ends the item before the divider starts.
// The input opens again once the result has moved to the output register,
// even if that register is still waiting to be taken.
// The sequencer reads the configuration registers as it goes: write them only
// while no item is in work.
module baro_pressure_temp_compensation_core
    import bptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bptc_sample_if.sink   sample,
    bptc_result_if.source result,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [63:0] wr_data
);

    logic [1:0]  oversampling_reg;
    logic [63:0] temp_cal_reg;
    logic [63:0] press_cal_a_reg;
    logic [31:0] press_cal_b_reg;

    logic        out_valid_reg;
    bptc_res_t   out_res_reg;

    logic        seq_idle;
    logic        seq_res_valid;
    bptc_res_t   seq_res;
    logic        take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oversampling_reg <= OVERSAMPLING_RESET;
            temp_cal_reg     <= '0;
            press_cal_a_reg  <= '0;
            press_cal_b_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_OVERSAMPLING: oversampling_reg <= wr_data[1:0];
                REG_TEMP_CAL:     temp_cal_reg     <= wr_data;
                REG_PRESS_CAL_A:  press_cal_a_reg  <= wr_data;
                REG_PRESS_CAL_B:  press_cal_b_reg  <= wr_data[31:0];
                default:          ;
            endcase
        end
    end

    bptc_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (sample.valid),
        .opcode       (sample.opcode),
        .raw          (sample.raw_reading),
        .oversampling (oversampling_reg),
        .temp_cal     (temp_cal_reg),
        .press_cal_a  (press_cal_a_reg),
        .press_cal_b  (press_cal_b_reg),
        .res_take     (take),
        .idle         (seq_idle),
        .res_valid    (seq_res_valid),
        .res          (seq_res)
    );

    assign sample.ready = seq_idle;

    // Move the result on when the output register is empty or being drained
    assign take = seq_res_valid && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= seq_res;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.kind  = out_res_reg.kind;
    assign result.value = out_res_reg.value;
    assign result.error = out_res_reg.error;

    // An error result always carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.error |-> result.value == 32'sd0)
        else $error("error result with non-zero value");

    // One item at a time: acceptance closes the input until the item is done
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("input still open after an item was accepted");

    // The output register only becomes valid when the sequencer hands over
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(seq_res_valid))
        else $error("result appeared without a finished item");

endmodule
